// File: rtl/core/clne_pkg.sv
package clne_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [12:0] WAIT_SHORT = 13'd100;
    localparam logic [12:0] WAIT_BYTE  = 13'd2100;
    localparam logic [12:0] WAIT_CLEAR = 13'd4100;

    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] NIB_4BIT     = 8'h02;
    localparam logic [7:0] BASE_LINE0   = 8'h80;
    localparam logic [7:0] BASE_LINE1   = 8'hC0;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam logic [63:0] RECIP_TEN = 64'h00000000CCCCCCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          MAX_DIGITS = 10;

    localparam logic [2:0] INIT_LAST_STEP = 3'd4;

    typedef enum logic [2:0] {
        OP_CMD   = 3'd0,
        OP_CHAR  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_GOTO  = 3'd3,
        OP_NUM   = 3'd4,
        OP_INIT  = 3'd5
    } op_t;

    // one queued display write: a byte, or a lone nibble in data[3:0]
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       lone;
        logic       long_wait;
        logic       last;
    } clne_entry_t;

    function automatic clne_entry_t init_entry(input logic [2:0] step);
        clne_entry_t e;
        e.rs        = 1'b0;
        e.lone      = 1'b0;
        e.long_wait = 1'b0;
        e.last      = 1'b0;
        e.data      = CMD_ENTRY;
        unique case (step)
            3'd0:
            begin
                e.data = NIB_4BIT;
                e.lone = 1'b1;
            end
            3'd1: e.data = CMD_FUNC_SET;
            3'd2: e.data = CMD_DISP_ON;
            3'd3:
            begin
                e.data      = CMD_CLEAR;
                e.long_wait = 1'b1;
            end
            default:
            begin
                e.data = CMD_ENTRY;
                e.last = 1'b1;
            end
        endcase
        return e;
    endfunction

endpackage

// File: rtl/core/clne_front.sv
module clne_front
    import clne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_op,
    input  logic [31:0] req_value,
    input  logic [7:0]  req_line,
    input  logic [7:0]  req_pos,
    output logic        push,
    output clne_entry_t push_entry,
    input  logic        full
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DIV_MUL,
        ST_DIV_REM,
        ST_POP,
        ST_INIT
    } state_t;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int DW = $clog2(MAX_DIGITS);

    state_t      state_reg;
    clne_entry_t entry_reg;
    logic [31:0] val_reg;
    logic [31:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  step_reg;
    logic [3:0]  digit_reg [MAX_DIGITS];

    logic [63:0] prod;
    logic [31:0] rem;
    logic [CW-1:0] top_idx;
    logic [7:0]  goto_base;
    clne_entry_t in_entry;

    assign prod      = {32'b0, val_reg} * RECIP_TEN;
    assign rem       = val_reg - ((quot_reg << 3) + (quot_reg << 1));
    assign top_idx   = cnt_reg - CW'(1);
    assign goto_base = (req_line <= 8'd1) ? BASE_LINE0 : BASE_LINE1;
    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        in_entry.lone      = 1'b0;
        in_entry.last      = 1'b1;
        in_entry.long_wait = 1'b0;
        in_entry.rs        = 1'b0;
        in_entry.data      = req_value[7:0];
        unique case (req_op)
            OP_CHAR:  in_entry.rs = 1'b1;
            OP_CLEAR:
            begin
                in_entry.data      = CMD_CLEAR;
                in_entry.long_wait = 1'b1;
            end
            OP_GOTO:  in_entry.data = goto_base + req_pos;
            default:  in_entry.data = req_value[7:0];
        endcase
    end

    always_comb
    begin
        push       = 1'b0;
        push_entry = entry_reg;
        unique case (state_reg)
            ST_EMIT: push = 1'b1;
            ST_POP:
            begin
                push               = 1'b1;
                push_entry.rs      = 1'b1;
                push_entry.lone    = 1'b0;
                push_entry.long_wait = 1'b0;
                push_entry.data    = ASCII_ZERO | {4'b0, digit_reg[top_idx[DW-1:0]]};
                push_entry.last    = (cnt_reg == CW'(1));
            end
            ST_INIT:
            begin
                push       = 1'b1;
                push_entry = init_entry(step_reg);
            end
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        entry_reg <= in_entry;
                        val_reg   <= req_value;
                        cnt_reg   <= '0;
                        step_reg  <= '0;
                        unique case (req_op)
                            OP_CMD, OP_CHAR, OP_CLEAR, OP_GOTO: state_reg <= ST_EMIT;
                            OP_NUM:  state_reg <= ST_DIV_MUL;
                            OP_INIT: state_reg <= ST_INIT;
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (!full)
                        state_reg <= ST_IDLE;
                end
                ST_DIV_MUL:
                begin
                    quot_reg  <= 32'(prod[63:RECIP_SHIFT]);
                    state_reg <= ST_DIV_REM;
                end
                ST_DIV_REM:
                begin
                    digit_reg[cnt_reg[DW-1:0]] <= rem[3:0];
                    cnt_reg <= cnt_reg + CW'(1);
                    val_reg <= quot_reg;
                    state_reg <= (quot_reg == 32'd0) ? ST_POP : ST_DIV_MUL;
                end
                ST_POP:
                begin
                    if (!full)
                    begin
                        cnt_reg <= top_idx;
                        if (cnt_reg == CW'(1))
                            state_reg <= ST_IDLE;
                    end
                end
                ST_INIT:
                begin
                    if (!full)
                    begin
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == INIT_LAST_STEP)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/clne_fifo.sv
module clne_fifo
    import clne_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  clne_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output clne_entry_t head,
    output logic        empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    clne_entry_t   mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + NW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - NW'(1);
        end
    end

endmodule

// File: rtl/core/clne_back.sv
module clne_back
    import clne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  clne_entry_t head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_rs,
    output logic [3:0]  out_nibble,
    output logic [12:0] out_wait,
    output logic        out_last
);

    logic        valid_reg;
    logic        low_reg;
    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic [12:0] wait_reg;
    logic        last_reg;
    logic        load;

    assign load       = (!valid_reg || out_ready) && !empty;
    assign pop        = load && (low_reg || head.lone);
    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_nibble = nibble_reg;
    assign out_wait   = wait_reg;
    assign out_last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            low_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            rs_reg    <= head.rs;
            if (low_reg)
            begin
                nibble_reg <= head.data[3:0];
                wait_reg   <= head.long_wait ? WAIT_CLEAR : WAIT_BYTE;
                last_reg   <= head.last;
                low_reg    <= 1'b0;
            end
            else if (head.lone)
            begin
                nibble_reg <= head.data[3:0];
                wait_reg   <= WAIT_SHORT;
                last_reg   <= head.last;
            end
            else
            begin
                nibble_reg <= head.data[7:4];
                wait_reg   <= WAIT_SHORT;
                last_reg   <= 1'b0;
                low_reg    <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/core/char_lcd_nibble_request_encoder_top.sv
// Character LCD 4-bit request encoder.
// Slave stream: one display request per word. tuser carries the request
// kind, tdata the value, line and position. Master stream: one nibble write
// per word, with tuser as the register-select level, tlast on the final
// nibble of a request, tdata the nibble and the wait after the enable pulse.
// A front stage decodes requests into byte writes and converts numbers to
// decimal, one digit at a time (reciprocal multiply, then remainder).
// A small queue feeds the back stage, which splits bytes into nibbles and
// presents one nibble per cycle on a registered output while the queue
// holds data and the receiver is ready. A new request is taken once the
// front stage has queued every byte of the previous one; a long number can
// fill the queue, and its last digits then wait for room in it.
// When the receiver stalls, the output word holds, the queue fills and
// then the front stage and slave tready stall in turn; nothing is dropped.
// Reset empties the queue and the output register and returns the front
// stage to idle.
module char_lcd_nibble_request_encoder_top
    import clne_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], line[39:32], pos[47:40]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // nibble[3:0], wait_us[16:4], zero[23:17]
    output logic        m_tuser,   // rs
    output logic        m_tlast
);

    logic        push;
    clne_entry_t push_entry;
    logic        full;
    logic        pop;
    clne_entry_t head;
    logic        empty;
    logic [3:0]  nibble;
    logic [12:0] wait_us;

    clne_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser),
        .req_value  (s_tdata[31:0]),
        .req_line   (s_tdata[39:32]),
        .req_pos    (s_tdata[47:40]),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    clne_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    clne_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (m_tuser),
        .out_nibble (nibble),
        .out_wait   (wait_us),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0, wait_us, nibble};

endmodule
